/* hdl/rlc_um_tx_segmenter_macros.svh */
// assertion macros for the rlc um transmit segmenter checker
`ifndef RLC_UM_TX_SEGMENTER_MACROS_SVH
`define RLC_UM_TX_SEGMENTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RLCUM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define RLCUM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rlcum_pkg.sv */
// shared types and constants of the rlc um transmit segmenter
`default_nettype none

package rlcum_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_SN_BITS     = 10;

    localparam int SDU_SN_W     = 12;
    localparam int LEN_W        = 16;
    localparam int BYTES_W      = 24;
    localparam int HDR_W        = 3;
    localparam int PDU_SN_W     = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 24;

    localparam logic [HDR_W-1:0] DEF_HEADER_BYTES = 3'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_BYTE_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES     = 2'd1;

    typedef enum logic [1:0] {
        OP_ARRIVAL = 2'd0,
        OP_GRANT   = 2'd1,
        OP_FLUSH   = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_DROPPED  = 3'd1,
        KIND_SEGMENT  = 3'd2,
        KIND_HEADER   = 3'd3,
        KIND_EMPTY    = 3'd4
    } kind_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [SDU_SN_W-1:0] sdu_sn;
        logic [LEN_W-1:0]    sdu_length;
        logic [LEN_W-1:0]    grant_bytes;
    } item_t;

    typedef struct packed {
        kind_t               kind;
        logic [SDU_SN_W-1:0] segment_sn;
        logic [LEN_W-1:0]    byte_count;
        logic [PDU_SN_W-1:0] pdu_sn;
        logic                first_is_fragment;
        logic                last_is_fragment;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [SDU_SN_W-1:0] sn;
        logic [LEN_W-1:0]    length;
    } desc_t;

    typedef struct packed {
        logic [BYTES_W-1:0] queue_byte_limit;
        logic [HDR_W-1:0]   header_bytes;
    } cfg_t;

endpackage

`default_nettype wire

/* hdl/rlcum_desc_mem.sv */
// sdu descriptor memory, one write port and one registered read port
`default_nettype none

module rlcum_desc_mem
    import rlcum_pkg::*;
#(
    parameter int DEPTH  = DEF_QUEUE_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire desc_t             wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output desc_t                  rd_data
);

    desc_t desc_mem [DEPTH];
    desc_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            desc_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= desc_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/rlcum_cfg_regs.sv */
// configuration registers: byte limit and header size
`default_nettype none

module rlcum_cfg_regs
    import rlcum_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.queue_byte_limit <= '0;
            cfg_reg.header_bytes     <= DEF_HEADER_BYTES;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_QUEUE_BYTE_LIMIT:
                begin
                    cfg_reg.queue_byte_limit <= cfg_data[BYTES_W-1:0];
                end
                CFG_HEADER_BYTES:
                begin
                    cfg_reg.header_bytes <= cfg_data[HDR_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

`default_nettype wire

/* hdl/rlcum_seq.sv */
// queue control and grant sequencer around the descriptor memory
`default_nettype none

module rlcum_seq
    import rlcum_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SN_BITS     = DEF_SN_BITS,
    parameter int PTR_W       = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire item_t            cmd,
    input  wire cfg_t             cfg,
    output logic                  result_valid,
    output result_t               result,
    output logic                  mem_wr_en,
    output logic [PTR_W-1:0]      mem_wr_addr,
    output desc_t                 mem_wr_data,
    output logic                  mem_rd_en,
    output logic [PTR_W-1:0]      mem_rd_addr,
    input  wire desc_t            mem_rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEG,
        ST_HDR
    } state_t;

    state_t             state_reg,       state_next;
    logic [PTR_W-1:0]   head_reg,        head_next;
    logic [PTR_W-1:0]   tail_reg,        tail_next;
    logic [CNT_W-1:0]   count_reg,       count_next;
    logic [BYTES_W-1:0] queued_reg,      queued_next;
    logic [LEN_W-1:0]   remaining_reg,   remaining_next;
    logic               partial_reg,     partial_next;
    logic               sfrag_reg,       sfrag_next;
    logic [SN_BITS-1:0] pdu_sn_reg,      pdu_sn_next;
    logic [LEN_W-1:0]   budget_reg,      budget_next;
    logic [LEN_W-1:0]   total_reg,       total_next;
    logic               start_frag_reg,  start_frag_next;
    logic               end_frag_reg,    end_frag_next;
    logic               res_valid_reg,   res_valid_next;
    result_t            res_reg,         res_next;

    logic               accept;
    logic [BYTES_W:0]   arr_sum;
    logic               arr_ok;
    logic [LEN_W:0]     grant_budget;
    logic               grant_go;
    logic [LEN_W-1:0]   seg_size;
    logic               seg_whole;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign arr_sum = {1'b0, queued_reg} + (BYTES_W + 1)'(cmd.sdu_length);
    assign arr_ok  = (cmd.sdu_length != '0)
                     && (count_reg < CNT_W'(QUEUE_DEPTH))
                     && !arr_sum[BYTES_W]
                     && ((cfg.queue_byte_limit == '0)
                         || (arr_sum[BYTES_W-1:0] < cfg.queue_byte_limit));

    assign grant_budget = {1'b0, cmd.grant_bytes} - (LEN_W + 1)'(cfg.header_bytes);
    assign grant_go     = !grant_budget[LEN_W] && (grant_budget[LEN_W-1:0] != '0)
                          && (count_reg != '0);

    assign seg_size  = partial_reg ? remaining_reg : mem_rd_data.length;
    assign seg_whole = (budget_reg >= seg_size);

    assign mem_wr_en          = accept && (cmd.opcode == OP_ARRIVAL) && arr_ok;
    assign mem_wr_addr        = tail_reg;
    assign mem_wr_data.sn     = cmd.sdu_sn;
    assign mem_wr_data.length = cmd.sdu_length;

    // the segment cycle prefetches the next descriptor
    assign mem_rd_en   = (state_reg == ST_LOAD) || (state_reg == ST_SEG);
    assign mem_rd_addr = (state_reg == ST_SEG) ? advance(head_reg) : head_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        queued_next     = queued_reg;
        remaining_next  = remaining_reg;
        partial_next    = partial_reg;
        sfrag_next      = sfrag_reg;
        pdu_sn_next     = pdu_sn_reg;
        budget_next     = budget_reg;
        total_next      = total_reg;
        start_frag_next = start_frag_reg;
        end_frag_next   = end_frag_reg;
        res_valid_next  = 1'b0;
        res_next        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.opcode)
                        OP_ARRIVAL:
                        begin
                            if (arr_ok)
                            begin
                                tail_next   = advance(tail_reg);
                                count_next  = count_reg + 1'b1;
                                queued_next = arr_sum[BYTES_W-1:0];
                            end
                            res_valid_next      = 1'b1;
                            res_next.kind       = arr_ok ? KIND_ACCEPTED : KIND_DROPPED;
                            res_next.segment_sn = cmd.sdu_sn;
                            res_next.byte_count = cmd.sdu_length;
                            res_next.last       = 1'b1;
                        end
                        OP_GRANT:
                        begin
                            if (grant_go)
                            begin
                                budget_next     = grant_budget[LEN_W-1:0];
                                total_next      = '0;
                                start_frag_next = sfrag_reg;
                                end_frag_next   = 1'b0;
                                state_next      = ST_LOAD;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                                res_next.kind  = KIND_EMPTY;
                                res_next.last  = 1'b1;
                            end
                        end
                        OP_FLUSH:
                        begin
                            head_next      = '0;
                            tail_next      = '0;
                            count_next     = '0;
                            queued_next    = '0;
                            remaining_next = '0;
                            partial_next   = 1'b0;
                            sfrag_next     = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SEG;
            end
            ST_SEG:
            begin
                res_valid_next      = 1'b1;
                res_next.kind       = KIND_SEGMENT;
                res_next.segment_sn = mem_rd_data.sn;
                if (seg_whole)
                begin
                    res_next.byte_count = seg_size;
                    budget_next         = budget_reg - seg_size;
                    total_next          = total_reg + seg_size;
                    queued_next         = queued_reg - BYTES_W'(mem_rd_data.length);
                    head_next           = advance(head_reg);
                    count_next          = count_reg - 1'b1;
                    partial_next        = 1'b0;
                    remaining_next      = '0;
                    sfrag_next          = 1'b0;
                    if ((count_reg > CNT_W'(1)) && (budget_reg != seg_size))
                    begin
                        state_next = ST_SEG;
                    end
                    else
                    begin
                        state_next = ST_HDR;
                    end
                end
                else
                begin
                    res_next.byte_count = budget_reg;
                    total_next          = total_reg + budget_reg;
                    remaining_next      = seg_size - budget_reg;
                    partial_next        = 1'b1;
                    sfrag_next          = 1'b1;
                    end_frag_next       = 1'b1;
                    budget_next         = '0;
                    state_next          = ST_HDR;
                end
            end
            ST_HDR:
            begin
                res_valid_next             = 1'b1;
                res_next.kind              = KIND_HEADER;
                res_next.byte_count        = total_reg + LEN_W'(cfg.header_bytes);
                res_next.pdu_sn            = PDU_SN_W'(pdu_sn_reg);
                res_next.first_is_fragment = start_frag_reg;
                res_next.last_is_fragment  = end_frag_reg;
                res_next.last              = 1'b1;
                pdu_sn_next                = pdu_sn_reg + 1'b1;
                state_next                 = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            queued_reg     <= '0;
            remaining_reg  <= '0;
            partial_reg    <= 1'b0;
            sfrag_reg      <= 1'b0;
            pdu_sn_reg     <= '0;
            budget_reg     <= '0;
            total_reg      <= '0;
            start_frag_reg <= 1'b0;
            end_frag_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            queued_reg     <= queued_next;
            remaining_reg  <= remaining_next;
            partial_reg    <= partial_next;
            sfrag_reg      <= sfrag_next;
            pdu_sn_reg     <= pdu_sn_next;
            budget_reg     <= budget_next;
            total_reg      <= total_next;
            start_frag_reg <= start_frag_next;
            end_frag_reg   <= end_frag_next;
            res_valid_reg  <= res_valid_next;
            res_reg        <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

/* hdl/rlc_um_tx_segmenter.sv */
// top level of the rlc um transmit segmenter
//
// An SDU arrival or a flush is taken while busy stays low; an
// arrival's accepted or dropped result shows on the cycle after the start
// beat, a flush shows none. A grant that carries data holds busy high while
// it packs n SDU pieces (at most QUEUE_DEPTH) in order: the first descriptor
// memory read, then one segment result a cycle while the next descriptor is
// prefetched, then the header result. A grant with no room or an empty
// queue gives its empty-PDU result on the next cycle without raising busy.
// Results are single-cycle strobes and cannot be held off, so the receiver
// must take one every cycle. The descriptor memory needs no clearing after
// reset.
`default_nettype none

module rlc_um_tx_segmenter
    import rlcum_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SN_BITS     = DEF_SN_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire item_t                  cmd,
    output logic                        result_valid,
    output result_t                     result,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cfg_t             cfg;
    logic             mem_wr_en;
    logic [PTR_W-1:0] mem_wr_addr;
    desc_t            mem_wr_data;
    logic             mem_rd_en;
    logic [PTR_W-1:0] mem_rd_addr;
    desc_t            mem_rd_data;

    rlcum_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlcum_desc_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_desc_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rlcum_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SN_BITS     (SN_BITS),
        .PTR_W       (PTR_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result       (result),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

endmodule

`default_nettype wire

/* hdl/rlcum_checker.sv */
// port-level assertion checker for the rlc um transmit segmenter, with bind
`default_nettype none

`include "rlc_um_tx_segmenter_macros.svh"

module rlcum_checker
    import rlcum_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire item_t   cmd,
    input wire logic    result_valid,
    input wire result_t result
);

    logic arrival_beat;
    logic quiet_beat;

    assign arrival_beat = start && !busy && (cmd.opcode == OP_ARRIVAL);
    assign quiet_beat   = start && !busy
                          && (cmd.opcode != OP_ARRIVAL) && (cmd.opcode != OP_GRANT);

    // arrival answers on the next cycle with a single final verdict
    `RLCUM_ASSERT_NEXT(a_arrival_answer, clk, rst_n, arrival_beat, result_valid && result.last && (result.kind == KIND_ACCEPTED || result.kind == KIND_DROPPED), "arrival beat not answered by one verdict")

    // flush and unused opcodes give no result
    `RLCUM_ASSERT_NEXT(a_quiet_no_result, clk, rst_n, quiet_beat, !result_valid, "result after flush or unused opcode")

    // a non-final result belongs to a grant still in progress
    `RLCUM_ASSERT_SAME(a_open_grant_busy, clk, rst_n, result_valid && !result.last, busy, "non-final result while idle")

    // a header always follows a segment on the previous cycle
    `RLCUM_ASSERT_SAME(a_header_after_seg, clk, rst_n, result_valid && result.kind == KIND_HEADER, $past(result_valid) && $past(result.kind) == KIND_SEGMENT && !$past(result.last), "header without preceding segment")

endmodule

bind rlc_um_tx_segmenter rlcum_checker u_rlcum_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

/* tb/rlc_um_tx_segmenter_tb.sv */
// self-checking testbench for the rlc um transmit segmenter, directed table then random phases
`timescale 1ns / 100ps

module rlc_um_tx_segmenter_tb;
    import rlcum_pkg::*;

    localparam int          QDEPTH        = DEF_QUEUE_DEPTH;
    localparam int unsigned BYTES_FULL    = 32'h00FF_FFFF;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          PHASE_ITEMS   = 48;
    localparam int          N_PHASES      = 7;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          MAX_SHOWN     = 10;

    localparam opcode_t                  OP_UNUSED   = opcode_t'(2'd3);
    localparam logic [CFG_INDEX_W-1:0]   CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0]   CFG_SPARE_B = 2'd3;

    typedef struct {
        item_t   cmd;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   start       = 1'b0;
    item_t                  cmd         = '0;
    logic                   cfg_valid   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   busy;
    logic                   result_valid;
    result_t                result;
    logic                   cfg_ready;

    // predictor state
    desc_t                  sdu_ring [QDEPTH];
    int                     rd_ptr        = 0;
    int                     wr_ptr        = 0;
    int                     sdu_count     = 0;
    int unsigned            byte_backlog  = 0;
    int unsigned            head_left     = 0;
    bit                     head_split    = 1'b0;
    bit                     open_fragment = 1'b0;
    logic [PDU_SN_W-1:0]    pdu_seq       = '0;
    logic [BYTES_W-1:0]     cur_limit     = '0;
    logic [HDR_W-1:0]       cur_hdr       = DEF_HEADER_BYTES;

    result_t                step_out [$];
    result_t                tx_results_due [$];
    dir_row_t               directed [$];

    int                     fail_count  = 0;
    int                     n_cmds      = 0;
    int                     n_checked   = 0;
    int                     n_dropped   = 0;
    int                     n_pdus      = 0;
    int                     max_pieces  = 0;
    bit                     quiet       = 1'b0;

    rlc_um_tx_segmenter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic item_t cmd_of(opcode_t op, int unsigned sn, int unsigned len,
                                     int unsigned grant);
        item_t it;
        it.opcode      = op;
        it.sdu_sn      = SDU_SN_W'(sn);
        it.sdu_length  = LEN_W'(len);
        it.grant_bytes = LEN_W'(grant);
        return it;
    endfunction

    function automatic result_t single_result(kind_t k, int unsigned sn, int unsigned cnt);
        result_t r;
        r            = '0;
        r.kind       = k;
        r.segment_sn = SDU_SN_W'(sn);
        r.byte_count = LEN_W'(cnt);
        r.last       = 1'b1;
        return r;
    endfunction

    // expected results of one command, left in step_out
    function automatic void tx_predict(input item_t it);
        int          budget;
        int unsigned total;
        int unsigned sum;
        int unsigned piece;
        bit          first_frag;
        bit          tail_frag;
        result_t     r;
        step_out.delete();
        case (it.opcode)
            OP_ARRIVAL:
            begin
                sum = byte_backlog + 32'(it.sdu_length);
                r   = '0;
                if (it.sdu_length != 0 && sdu_count < QDEPTH && sum <= BYTES_FULL &&
                    (cur_limit == 0 || sum < 32'(cur_limit)))
                begin
                    sdu_ring[wr_ptr].sn     = it.sdu_sn;
                    sdu_ring[wr_ptr].length = it.sdu_length;
                    wr_ptr       = (wr_ptr + 1) % QDEPTH;
                    sdu_count    = sdu_count + 1;
                    byte_backlog = sum;
                    r.kind       = KIND_ACCEPTED;
                end
                else
                begin
                    r.kind    = KIND_DROPPED;
                    n_dropped = n_dropped + 1;
                end
                r.segment_sn = it.sdu_sn;
                r.byte_count = it.sdu_length;
                r.last       = 1'b1;
                step_out.push_back(r);
            end
            OP_GRANT:
            begin
                budget     = int'(it.grant_bytes) - int'(cur_hdr);
                total      = 0;
                first_frag = open_fragment;
                tail_frag  = 1'b0;
                while (sdu_count > 0 && budget > 0)
                begin
                    piece        = head_split ? head_left : 32'(sdu_ring[rd_ptr].length);
                    r            = '0;
                    r.kind       = KIND_SEGMENT;
                    r.segment_sn = sdu_ring[rd_ptr].sn;
                    if (budget >= int'(piece))
                    begin
                        r.byte_count  = LEN_W'(piece);
                        budget        = budget - int'(piece);
                        total         = total + piece;
                        byte_backlog  = (byte_backlog - 32'(sdu_ring[rd_ptr].length)) & BYTES_FULL;
                        rd_ptr        = (rd_ptr + 1) % QDEPTH;
                        sdu_count     = sdu_count - 1;
                        head_split    = 1'b0;
                        head_left     = 0;
                        open_fragment = 1'b0;
                    end
                    else
                    begin
                        r.byte_count  = LEN_W'(budget);
                        total         = total + 32'(budget);
                        head_left     = piece - 32'(budget);
                        head_split    = 1'b1;
                        open_fragment = 1'b1;
                        tail_frag     = 1'b1;
                        budget        = 0;
                    end
                    step_out.push_back(r);
                end
                if (total == 0)
                begin
                    step_out.delete();
                    step_out.push_back(single_result(KIND_EMPTY, 0, 0));
                end
                else
                begin
                    r                   = '0;
                    r.kind              = KIND_HEADER;
                    r.byte_count        = LEN_W'(32'(cur_hdr) + total);
                    r.pdu_sn            = pdu_seq;
                    r.first_is_fragment = first_frag;
                    r.last_is_fragment  = tail_frag;
                    r.last              = 1'b1;
                    step_out.push_back(r);
                    pdu_seq = pdu_seq + 1'b1;
                    n_pdus  = n_pdus + 1;
                    if (step_out.size() > max_pieces)
                        max_pieces = step_out.size();
                end
            end
            OP_FLUSH:
            begin
                rd_ptr        = 0;
                wr_ptr        = 0;
                sdu_count     = 0;
                byte_backlog  = 0;
                head_left     = 0;
                head_split    = 1'b0;
                open_fragment = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic item_t draw_item();
        item_t       it;
        int unsigned pick;
        it.sdu_sn = SDU_SN_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.opcode = OP_ARRIVAL;
        else if (pick < 95)
            it.opcode = OP_GRANT;
        else if (pick < 98)
            it.opcode = OP_FLUSH;
        else
            it.opcode = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            it.sdu_length = LEN_W'($urandom_range(1, 300));
        else if (pick < 90)
            it.sdu_length = LEN_W'($urandom_range(1, 4000));
        else if (pick < 98)
            it.sdu_length = LEN_W'($urandom);
        else
            it.sdu_length = '0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            it.grant_bytes = LEN_W'($urandom_range(0, 600));
        else if (pick < 80)
            it.grant_bytes = LEN_W'($urandom_range(0, 5000));
        else if (pick < 90)
            it.grant_bytes = LEN_W'($urandom_range(0, 8));
        else
            it.grant_bytes = LEN_W'($urandom);
        return it;
    endfunction

    task automatic log_fault(input string why, input result_t want, input result_t got);
        fail_count = fail_count + 1;
        if (fail_count <= MAX_SHOWN)
        begin
            $display("%0t %s: want kind=%0d sn=%0h cnt=%0d psn=%0d ff=%0b lf=%0b last=%0b",
                     $realtime, why,
                     want.kind, want.segment_sn, want.byte_count, want.pdu_sn,
                     want.first_is_fragment, want.last_is_fragment, want.last);
            $display("    got kind=%0d sn=%0h cnt=%0d psn=%0d ff=%0b lf=%0b last=%0b",
                     got.kind, got.segment_sn, got.byte_count, got.pdu_sn,
                     got.first_is_fragment, got.last_is_fragment, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if ($isunknown(result_valid))
                log_fault("result_valid unknown", '0, result);
            else if (result_valid)
            begin
                if (tx_results_due.size() == 0)
                    log_fault("unexpected result", '0, result);
                else
                begin
                    want      = tx_results_due.pop_front();
                    n_checked = n_checked + 1;
                    if (result.kind !== want.kind || result.segment_sn !== want.segment_sn ||
                        result.byte_count !== want.byte_count || result.pdu_sn !== want.pdu_sn ||
                        result.first_is_fragment !== want.first_is_fragment ||
                        result.last_is_fragment !== want.last_is_fragment ||
                        result.last !== want.last)
                        log_fault("result mismatch", want, result);
                end
            end
        end
    end

    // holds start until a beat goes through, then queues what that command must produce
    task automatic issue_cmd(input item_t it, input bit typed, input result_t want);
        cmd   <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tx_predict(it);
        if (typed)
            tx_results_due.push_back(want);
        else
            foreach (step_out[i])
                tx_results_due.push_back(step_out[i]);
        n_cmds = n_cmds + 1;
    endtask

    task automatic pace();
        if (!quiet && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (tx_results_due.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard = guard + 1;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == CFG_QUEUE_BYTE_LIMIT)
            cur_limit = d;
        else if (idx == CFG_HEADER_BYTES)
            cur_hdr = d[HDR_W-1:0];
    endtask

    task automatic program_regs(input logic [BYTES_W-1:0] limit, input logic [HDR_W-1:0] hdr,
                                input bit poke_spare);
        write_reg(CFG_QUEUE_BYTE_LIMIT, limit);
        write_reg(CFG_HEADER_BYTES, {21'($urandom), hdr});
        if (poke_spare)
        begin
            write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
            write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        item_t            it;
        logic [BYTES_W-1:0] limit;
        logic [HDR_W-1:0] hdr;
        int               issued;
        int               guard;

        // reset defaults: no byte limit, two byte header
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 0), 1'b1, single_result(KIND_EMPTY, 0, 0)});
        directed.push_back('{cmd_of(OP_ARRIVAL, 0, 0, 0), 1'b1,
                             single_result(KIND_DROPPED, 0, 0)});
        directed.push_back('{cmd_of(OP_ARRIVAL, 12'hFFF, 16'hFFFF, 16'hFFFF), 1'b1,
                             single_result(KIND_ACCEPTED, 12'hFFF, 16'hFFFF)});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 2), 1'b1, single_result(KIND_EMPTY, 0, 0)});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 3), 1'b0, '0});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 16'hFFFF), 1'b0, '0});
        directed.push_back('{cmd_of(OP_ARRIVAL, 1, 100, 0), 1'b1,
                             single_result(KIND_ACCEPTED, 1, 100)});
        directed.push_back('{cmd_of(OP_ARRIVAL, 2, 200, 0), 1'b1,
                             single_result(KIND_ACCEPTED, 2, 200)});
        directed.push_back('{cmd_of(OP_ARRIVAL, 3, 1, 0), 1'b1,
                             single_result(KIND_ACCEPTED, 3, 1)});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 302), 1'b0, '0});
        directed.push_back('{cmd_of(OP_UNUSED, 7, 5, 9), 1'b0, '0});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 1), 1'b1, single_result(KIND_EMPTY, 0, 0)});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 3), 1'b0, '0});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 16'hFFFF), 1'b0, '0});
        directed.push_back('{cmd_of(OP_ARRIVAL, 12'hAAA, 16'h5555, 16'hAAAA), 1'b1,
                             single_result(KIND_ACCEPTED, 12'hAAA, 16'h5555)});
        directed.push_back('{cmd_of(OP_ARRIVAL, 12'h555, 16'hAAAA, 16'h5555), 1'b1,
                             single_result(KIND_ACCEPTED, 12'h555, 16'hAAAA)});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 16'h5557), 1'b0, '0});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 16'h1000), 1'b0, '0});
        directed.push_back('{cmd_of(OP_FLUSH, 12'hFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 16'hFFFF), 1'b1,
                             single_result(KIND_EMPTY, 0, 0)});
        directed.push_back('{cmd_of(OP_ARRIVAL, 12'h800, 16'h8000, 0), 1'b1,
                             single_result(KIND_ACCEPTED, 12'h800, 16'h8000)});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 16'h7FFF), 1'b0, '0});
        directed.push_back('{cmd_of(OP_GRANT, 0, 0, 16'hFFFF), 1'b0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            issue_cmd(directed[i].cmd, directed[i].typed, directed[i].want);
            pace();
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    limit = 24'd1;
                    hdr   = 3'd1;
                end
                1:
                begin
                    limit = 24'hFF_FFFF;
                    hdr   = 3'd4;
                end
                2:
                begin
                    limit = BYTES_W'($urandom_range(500, 3000));
                    hdr   = 3'd0;
                end
                3:
                begin
                    limit = '0;
                    hdr   = 3'd7;
                end
                4:
                begin
                    limit = BYTES_W'($urandom_range(100, 800));
                    hdr   = 3'd5;
                end
                5:
                begin
                    limit = '0;
                    hdr   = 3'd6;
                end
                default:
                begin
                    limit = '0;
                    hdr   = DEF_HEADER_BYTES;
                end
            endcase
            settle();
            program_regs(limit, hdr, ph == 3);
            quiet  = (ph == 5);
            issued = 0;
            while (issued < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    // overfill the store, then drain it with one maximal grant
                    repeat (QDEPTH + 1)
                    begin
                        it            = draw_item();
                        it.opcode     = OP_ARRIVAL;
                        it.sdu_length = LEN_W'($urandom_range(1, 60));
                        issue_cmd(it, 1'b0, '0);
                        pace();
                    end
                    it             = draw_item();
                    it.opcode      = OP_GRANT;
                    it.grant_bytes = 16'hFFFF;
                    issue_cmd(it, 1'b0, '0);
                    pace();
                    issued = issued + QDEPTH + 2;
                end
                else
                begin
                    issue_cmd(draw_item(), 1'b0, '0);
                    pace();
                    issued = issued + 1;
                end
            end
        end

        start <= 1'b0;
        guard = 0;
        while (tx_results_due.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard = guard + 1;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tx_results_due.size() != 0)
        begin
            $display("%0d expected results never arrived", tx_results_due.size());
            fail_count = fail_count + tx_results_due.size();
        end

        $display("%0d commands over %0d register settings, %0d results checked",
                 n_cmds, N_PHASES + 1, n_checked);
        $display("%0d pdus built, %0d sdus dropped, up to %0d results from one grant",
                 n_pdus, n_dropped, max_pieces);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
